// ----- hdl/tkd_pkg.sv -----
// Shared constants and types for the top-k distinct score table.
package tkd_pkg;

   localparam int SCORE_W         = 32;
   localparam int RANK_W          = 6;
   localparam int DEF_TABLE_DEPTH = 5;

   // Per-cycle commands broadcast along the cell chain
   typedef struct packed {
      logic capture;   // compare the incoming request against the entry
      logic commit;    // shift/insert the captured score
      logic rotate;    // pass entries one step toward cell 0
   } cell_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_UPD  = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

endpackage

// ----- hdl/tkd_cell.sv -----
// One table cell: holds one entry, its compare flags, and links to its neighbors.
module tkd_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tkd_pkg::cell_ctrl_type               ctrl,
   input  logic signed [tkd_pkg::SCORE_W-1:0]   req_score,
   input  logic signed [tkd_pkg::SCORE_W-1:0]   score,
   input  logic                                 insert,
   input  logic                                 prev_gt,
   input  logic signed [tkd_pkg::SCORE_W-1:0]   prev_entry,
   input  logic signed [tkd_pkg::SCORE_W-1:0]   next_entry,
   output logic signed [tkd_pkg::SCORE_W-1:0]   entry,
   output logic                                 gt,
   output logic                                 eq
);
   import tkd_pkg::*;

   logic signed [SCORE_W-1:0] entry_ff, entry_in;
   logic                      gt_ff, eq_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.commit && insert && !gt_ff) begin
         entry_in = prev_gt ? score : prev_entry;
      end else if (ctrl.rotate) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         gt_ff <= entry_ff > req_score;
         eq_ff <= entry_ff == req_score;
      end
   end

   assign entry = entry_ff;
   assign gt    = gt_ff;
   assign eq    = eq_ff;

endmodule

// ----- hdl/top_k_distinct_score_table.sv -----
// Top level of the top-k distinct score table: cell chain, sequencer and result register.
// An accepted request is compared, committed in ST_UPD, and its rank-0 result loaded
//   into the result register; the other TABLE_DEPTH-1 results follow one per cycle while
//   rsp_ready is high, the chain rotating once per result; a new request waits for idle.
// Reset (synchronous, active high) clears every table entry to zero, empties the
//   result register and returns the sequencer to idle.
module top_k_distinct_score_table #(
   parameter int TABLE_DEPTH = tkd_pkg::DEF_TABLE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [tkd_pkg::SCORE_W-1:0]   req_score,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [tkd_pkg::SCORE_W-1:0]   rsp_entry_value,
   output logic        [tkd_pkg::RANK_W-1:0]    rsp_entry_rank,
   output logic                                 rsp_last_entry,
   output logic                                 rsp_inserted,
   output logic                                 rsp_duplicate
);
   import tkd_pkg::*;

   localparam logic [RANK_W-1:0] LAST_RANK = RANK_W'(TABLE_DEPTH - 1);

   state_type                 state_ff, state_in;
   logic [RANK_W-1:0]         cnt_ff, cnt_in;
   logic signed [SCORE_W-1:0] score_ff;
   logic                      ins_ff, dup_ff;

   logic signed [SCORE_W-1:0] cell_entry [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]    cell_gt, cell_eq;
   cell_ctrl_type             ctrl;

   logic                      req_fire, rsp_load, dup_w, ins_w;

   logic signed [SCORE_W-1:0] out_value_ff;
   logic [RANK_W-1:0]         out_rank_ff;
   logic                      out_valid_ff, out_last_ff, out_ins_ff, out_dup_ff;

   // Offer decision: any equal entry marks a duplicate; otherwise the score
   // enters unless the last entry is already above it.
   assign dup_w = |cell_eq;
   assign ins_w = !dup_w && !cell_gt[TABLE_DEPTH-1];

   assign req_ready = state_ff == ST_IDLE;
   assign req_fire  = req_valid && req_ready;
   // During the emit pass, load the result register whenever it is empty or being drained.
   assign rsp_load  = (state_ff == ST_EMIT) && (!out_valid_ff || rsp_ready);

   always_comb begin
      ctrl.capture = req_fire;
      ctrl.commit  = state_ff == ST_UPD;
      ctrl.rotate  = rsp_load;
   end

   // Cell chain: entry i receives from i-1 on insert and from i+1 on rotate,
   // the last cell wraps to cell 0 so a full emit pass restores the order.
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      localparam int NEXT = (i + 1) % TABLE_DEPTH;
      logic                      prev_gt;
      logic signed [SCORE_W-1:0] prev_entry;
      if (i == 0) begin : g_head
         assign prev_gt    = 1'b1;
         assign prev_entry = score_ff;
      end else begin : g_body
         assign prev_gt    = cell_gt[i-1];
         assign prev_entry = cell_entry[i-1];
      end
      tkd_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .req_score  (req_score),
         .score      (score_ff),
         .insert     (ins_w),
         .prev_gt    (prev_gt),
         .prev_entry (prev_entry),
         .next_entry (cell_entry[NEXT]),
         .entry      (cell_entry[i]),
         .gt         (cell_gt[i]),
         .eq         (cell_eq[i])
      );
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_UPD;
         end
         ST_UPD: begin
            state_in = ST_EMIT;
            cnt_in   = '0;
         end
         ST_EMIT: begin
            if (rsp_load) begin
               if (cnt_ff == LAST_RANK) begin
                  state_in = ST_IDLE;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (rsp_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the request score and the offer flags for the whole run.
   always_ff @(posedge clock) begin
      if (req_fire) score_ff <= req_score;
      if (state_ff == ST_UPD) begin
         ins_ff <= ins_w;
         dup_ff <= dup_w;
      end
      if (rsp_load) begin
         out_value_ff <= cell_entry[0];
         out_rank_ff  <= cnt_ff;
         out_last_ff  <= cnt_ff == LAST_RANK;
         out_ins_ff   <= ins_ff;
         out_dup_ff   <= dup_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_entry_value = out_value_ff;
   assign rsp_entry_rank  = out_rank_ff;
   assign rsp_last_entry  = out_last_ff;
   assign rsp_inserted    = out_ins_ff;
   assign rsp_duplicate   = out_dup_ff;

endmodule

// ----- hdl/tkd_checker.sv -----
// Port-level checker for the top-k distinct score table, bound to the top level.
module tkd_checker #(
   parameter int TABLE_DEPTH = tkd_pkg::DEF_TABLE_DEPTH
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic signed [tkd_pkg::SCORE_W-1:0]   req_score,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [tkd_pkg::SCORE_W-1:0]   rsp_entry_value,
   input logic        [tkd_pkg::RANK_W-1:0]    rsp_entry_rank,
   input logic                                 rsp_last_entry,
   input logic                                 rsp_inserted,
   input logic                                 rsp_duplicate
);
   import tkd_pkg::*;

   localparam logic [RANK_W-1:0] LAST_RANK = RANK_W'(TABLE_DEPTH - 1);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_score))
      else $error("waiting request dropped or changed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_value)
                                 && $stable(rsp_entry_rank))
      else $error("stalled result changed");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_inserted && rsp_duplicate))
      else $error("result flagged both inserted and duplicate");

   a_last_rank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_entry == (rsp_entry_rank == LAST_RANK)))
      else $error("last marker not on the lowest rank");

   a_run_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_entry |=>
         rsp_valid
         && rsp_entry_rank == RANK_W'($past(rsp_entry_rank) + 1'b1)
         && rsp_entry_value <= $past(rsp_entry_value)
         && rsp_inserted == $past(rsp_inserted)
         && rsp_duplicate == $past(rsp_duplicate))
      else $error("run not contiguous, ascending in rank and descending in value");

endmodule

bind top_k_distinct_score_table tkd_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_tkd_checker (.*);

// ----- verif/testbench.sv -----
// Self-checking testbench for the top-k distinct score table.
`timescale 1ns / 100ps

module testbench;
   import tkd_pkg::*;

   localparam int DEPTH            = DEF_TABLE_DEPTH;
   localparam int HALF_PERIOD      = 6;
   localparam int RESET_CYCLES     = 6;
   localparam int RANDOM_PER_PHASE = 97;
   localparam int REPORT_LIMIT     = 10;
   localparam longint SCORE_MAX    = 64'sd2147483647;
   localparam longint SCORE_MIN    = -64'sd2147483648;

   // Directed opening: zero and negatives against the all-zero reset table, the
   // field extremes, fills at every position but the last, duplicates at top and
   // bottom, and scores that fall just below the lowest entry.
   localparam logic signed [SCORE_W-1:0] DIRECTED_SCORES [20] = '{
      32'sd0,                 // duplicate of the cleared entries
      -32'sd1,                // below every entry, dropped
      32'sh8000_0000,         // most negative score, dropped
      32'sd5,                 // first insert, lands on top
      32'sd5,                 // duplicate of the top entry
      32'sd3,
      32'sd7,
      32'sd1,                 // table now 7 5 3 1 0
      32'sd0,                 // duplicate of the lowest entry
      -32'sd5,                // below every entry
      32'sd4,                 // insert in the middle
      32'sh7FFF_FFFF,         // most positive score, new top
      32'sd2,                 // below every entry, dropped
      32'sd1,                 // the value pushed out by the new top: not a duplicate any more
      32'sh7FFF_FFFF,         // duplicate of the top entry
      32'sd6,
      32'sh8000_0000,
      32'sh7FFF_FFFE,         // insert just below the top
      32'sh5555_AAAA,
      32'sh2AAA_5555
   };

   typedef struct packed {
      logic signed [SCORE_W-1:0] value;
      logic        [RANK_W-1:0]  rank;
      logic                      last_entry;
      logic                      inserted;
      logic                      duplicate;
   } entry_rsp_type;

   // Holds the expected table and the table entries still owed by the block.
   class score_board;
      logic signed [SCORE_W-1:0] ranked_scores [DEPTH];
      entry_rsp_type             owed_entries [$];
      int                        offers, inserts, duplicates, checked, errors;

      function new();
         foreach (ranked_scores[i]) ranked_scores[i] = '0;
         offers = 0; inserts = 0; duplicates = 0; checked = 0; errors = 0;
      endfunction

      // Merge an accepted score into the table and queue the full table dump.
      function void note_offer(logic signed [SCORE_W-1:0] score);
         bit            dup;
         bit            ins;
         int            pos;
         entry_rsp_type entry;
         dup = 1'b0;
         ins = 1'b0;
         foreach (ranked_scores[i]) if (ranked_scores[i] == score) dup = 1'b1;
         if (!dup && score > ranked_scores[DEPTH-1]) begin
            pos = 0;
            while (pos < DEPTH && ranked_scores[pos] > score) pos++;
            for (int i = DEPTH - 1; i > pos; i--) ranked_scores[i] = ranked_scores[i-1];
            ranked_scores[pos] = score;
            ins = 1'b1;
            inserts++;
         end
         if (dup) duplicates++;
         offers++;
         for (int i = 0; i < DEPTH; i++) begin
            entry.value      = ranked_scores[i];
            entry.rank       = RANK_W'(i);
            entry.last_entry = (i == DEPTH - 1);
            entry.inserted   = ins;
            entry.duplicate  = dup;
            owed_entries.push_back(entry);
         end
      endfunction

      // Compare one emitted entry with the oldest owed one.
      function void check_entry(entry_rsp_type got);
         entry_rsp_type want;
         if (owed_entries.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("ERROR: unexpected entry value=%0d rank=%0d at %0t",
                        got.value, got.rank, $realtime);
            return;
         end
         want = owed_entries.pop_front();
         checked++;
         if (got.value !== want.value || got.rank !== want.rank ||
             got.last_entry !== want.last_entry || got.inserted !== want.inserted ||
             got.duplicate !== want.duplicate) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display({"ERROR: entry %0d at %0t: expected value=%0d rank=%0d last=%0b ",
                         "ins=%0b dup=%0b, got value=%0d rank=%0d last=%0b ins=%0b dup=%0b"},
                        checked, $realtime, want.value, want.rank, want.last_entry,
                        want.inserted, want.duplicate, got.value, got.rank,
                        got.last_entry, got.inserted, got.duplicate);
         end
      endfunction

      function int pending();
         return owed_entries.size();
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [SCORE_W-1:0] req_score = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [SCORE_W-1:0] rsp_entry_value;
   logic        [RANK_W-1:0]  rsp_entry_rank;
   logic                      rsp_last_entry;
   logic                      rsp_inserted;
   logic                      rsp_duplicate;

   int send_idle_pct = 34;
   int recv_idle_pct = 61;

   score_board board = new();

   always #(HALF_PERIOD) clock = ~clock;

   top_k_distinct_score_table #(
      .TABLE_DEPTH(DEPTH)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_score      (req_score),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_entry_value(rsp_entry_value),
      .rsp_entry_rank (rsp_entry_rank),
      .rsp_last_entry (rsp_last_entry),
      .rsp_inserted   (rsp_inserted),
      .rsp_duplicate  (rsp_duplicate)
   );

   // Stall the result side at random; the stall rate follows the current phase.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Check every entry the block hands over.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_entry('{rsp_entry_value, rsp_entry_rank, rsp_last_entry,
                             rsp_inserted, rsp_duplicate});
   end

   // Offer one score: idle at random first (with junk on the bus), then hold
   // valid and the score until the block takes the request.
   task automatic offer_score(input logic signed [SCORE_W-1:0] score);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_score <= $urandom;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_score <= score;
      do @(posedge clock); while (!req_ready);
      board.note_offer(score);
   endtask

   // Drop valid and hold off until every owed entry has come back.
   task automatic drain_table();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   initial begin
      int                        kind;
      longint                    lowest;
      longint                    highest;
      longint                    span;
      longint                    pick;
      logic signed [SCORE_W-1:0] score;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_SCORES[i]) offer_score(DIRECTED_SCORES[i]);
      drain_table();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 34; recv_idle_pct = 61; end
            1: begin send_idle_pct = 61; recv_idle_pct = 34; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            kind    = $urandom_range(99);
            lowest  = board.ranked_scores[DEPTH-1];
            highest = board.ranked_scores[0];
            if (kind < 25) begin
               // Full-range score: walks every bit of the field.
               score = $urandom;
            end else if (kind < 50) begin
               // Repeat an entry that is in the table now.
               score = board.ranked_scores[$urandom_range(DEPTH - 1)];
            end else if (kind < 85) begin
               // Land anywhere from just above the lowest entry to a bit past the top.
               span = highest - lowest + 64;
               if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
               pick = lowest + longint'($urandom_range(1, int'(span)));
               if (pick > SCORE_MAX) pick = SCORE_MAX;
               score = pick[SCORE_W-1:0];
            end else begin
               // Hug the lowest entry from below, equal included.
               pick = lowest - longint'($urandom_range(0, 3));
               if (pick < SCORE_MIN) pick = SCORE_MIN;
               score = pick[SCORE_W-1:0];
            end
            offer_score(score);
         end
         drain_table();
      end

      // Let any late entry show up before judging.
      repeat (DEPTH + 4) @(posedge clock);

      $display("Covered %0d requests (%0d inserted, %0d duplicates), %0d entries checked,",
               board.offers, board.inserts, board.duplicates, board.checked);
      $display("across three idle/stall mixes; %0d mismatches, %0d entries still owed.",
               board.errors, board.pending());
      if (board.errors == 0 && board.pending() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

   // Hard stop well past the slowest legal run.
   initial begin
      #5_000_000;
      $display("Timeout with %0d entries still owed.", board.pending());
      $display("testbench NOT OK");
      $finish;
   end

endmodule
